// ===== rtl/core/ifw_pkg.sv =====
package ifw_pkg;

    localparam logic [31:0] TAG_FORM = 32'h464F524D;
    localparam logic [31:0] TAG_8SVX = 32'h38535658;
    localparam logic [31:0] TAG_VHDR = 32'h56484452;
    localparam logic [31:0] TAG_BODY = 32'h424F4459;
    localparam logic [31:0] TAG_NAME = 32'h4E414D45;
    localparam logic [31:0] TAG_AUTH = 32'h41555448;
    localparam logic [31:0] TAG_COPY = 32'h28632920;
    localparam logic [31:0] TAG_ANNO = 32'h414E4E4F;

    localparam logic [32:0] IDX_MAX   = 33'h1_FFFF_FFFF;
    localparam logic [32:0] IDX_START = 33'd4;
    localparam logic [15:0] TEXT_MAX  = 16'hFFFF;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        EV_FORM_OK    = 3'd0,
        EV_FORM_BAD   = 3'd1,
        EV_VOICE_HDR  = 3'd2,
        EV_BODY_START = 3'd3,
        EV_TEXT       = 3'd4,
        EV_OTHER      = 3'd5,
        EV_END_ONLY   = 3'd6
    } ifw_code_t;

    typedef enum logic [1:0] {
        TK_NAME = 2'd0,
        TK_AUTH = 2'd1,
        TK_COPY = 2'd2,
        TK_ANNO = 2'd3
    } ifw_text_kind_t;

    typedef struct packed {
        ifw_code_t      code;
        logic           done;
        logic [31:0]    size;
        logic [15:0]    rate;
        logic [31:0]    offset;
        ifw_text_kind_t kind;
        logic [15:0]    count;
    } ifw_event_t;

    function automatic logic is_text_tag(input logic [31:0] id);
        return (id == TAG_NAME) || (id == TAG_AUTH) || (id == TAG_COPY) || (id == TAG_ANNO);
    endfunction

    function automatic ifw_text_kind_t text_kind_of(input logic [31:0] id);
        ifw_text_kind_t k;
        priority if (id == TAG_NAME)
            k = TK_NAME;
        else if (id == TAG_AUTH)
            k = TK_AUTH;
        else if (id == TAG_COPY)
            k = TK_COPY;
        else
            k = TK_ANNO;
        return k;
    endfunction

endpackage

// ===== rtl/core/ifw_channels.sv =====
interface ifw_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_file;

    modport source (output valid, output data_byte, output start_of_file, input ready);
    modport sink (input valid, input data_byte, input start_of_file, output ready);
endinterface

interface ifw_event_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_code;
    logic        parse_done;
    logic [31:0] chunk_size;
    logic [15:0] sample_rate;
    logic [31:0] byte_offset;
    logic [1:0]  text_kind;
    logic [15:0] text_count;

    modport source (output valid, output event_code, output parse_done, output chunk_size,
                    output sample_rate, output byte_offset, output text_kind,
                    output text_count, input ready);
    modport sink (input valid, input event_code, input parse_done, input chunk_size,
                  input sample_rate, input byte_offset, input text_kind,
                  input text_count, output ready);
endinterface

// ===== rtl/core/ifw_front.sv =====
module ifw_front (
    input  logic              clk,
    input  logic              rst_n,
    ifw_byte_if.sink          byte_ch,
    input  logic              space,
    output logic              evt_valid,
    output ifw_pkg::ifw_event_t evt
);
    import ifw_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_FORM,
        PH_CHDR,
        PH_LOAD,
        PH_PAD,
        PH_DONE,
        PH_FAIL
    } phase_t;

    phase_t      phase_reg, phase_next, cur_phase;
    logic [31:0] fc_reg, fc_next, cur_fc;
    logic [31:0] fsz_reg, fsz_next, cur_fsz;
    logic [32:0] ci_reg, ci_next, cur_ci;
    logic [31:0] id_reg, id_next, cur_id;
    logic [31:0] sz_reg, sz_next, cur_sz;
    logic [15:0] rate_reg, rate_next, cur_rate;
    logic [15:0] txt_reg, txt_next, cur_txt;
    logic [31:0] offs_reg, offs_next, cur_offs;

    logic        accept;
    logic        start;
    logic [7:0]  b;
    logic        cur_active;
    logic [31:0] id_shifted;
    logic [31:0] sz_shifted;
    logic [31:0] fc_inc;
    logic [34:0] idx_sum;
    logic [32:0] idx_sat;
    logic        head_done;
    logic        tail_done;
    logic        finish;

    assign byte_ch.ready = space;
    assign accept        = byte_ch.valid & space;
    assign start         = byte_ch.start_of_file;
    assign b             = byte_ch.data_byte;

    // A start byte restarts the parse and is then handled as file byte 0.
    always_comb
    begin
        if (start)
        begin
            cur_phase = PH_FORM;
            cur_fc    = '0;
            cur_fsz   = '0;
            cur_ci    = IDX_START;
            cur_id    = '0;
            cur_sz    = '0;
            cur_rate  = '0;
            cur_txt   = '0;
            cur_offs  = '0;
        end
        else
        begin
            cur_phase = phase_reg;
            cur_fc    = fc_reg;
            cur_fsz   = fsz_reg;
            cur_ci    = ci_reg;
            cur_id    = id_reg;
            cur_sz    = sz_reg;
            cur_rate  = rate_reg;
            cur_txt   = txt_reg;
            cur_offs  = offs_reg;
        end
    end

    assign cur_active = (cur_phase == PH_FORM) || (cur_phase == PH_CHDR) ||
                        (cur_phase == PH_LOAD) || (cur_phase == PH_PAD);
    assign id_shifted = {cur_id[23:0], b};
    assign sz_shifted = {cur_sz[23:0], b};
    assign fc_inc     = cur_fc + 32'd1;

    // Next chunk index: size plus header, rounded up to even, saturating.
    assign idx_sum = {2'b00, cur_ci} + {3'b000, sz_shifted} + 35'd8 +
                     {34'd0, cur_ci[0] ^ sz_shifted[0]};
    assign idx_sat   = (idx_sum > {2'b00, IDX_MAX}) ? IDX_MAX : idx_sum[32:0];
    assign head_done = idx_sat >= {1'b0, cur_fsz};
    assign tail_done = cur_ci >= {1'b0, cur_fsz};

    always_comb
    begin
        phase_next = phase_reg;
        fc_next    = fc_reg;
        fsz_next   = fsz_reg;
        ci_next    = ci_reg;
        id_next    = id_reg;
        sz_next    = sz_reg;
        rate_next  = rate_reg;
        txt_next   = txt_reg;
        offs_next  = offs_reg;
        evt_valid  = 1'b0;
        evt        = '0;
        finish     = 1'b0;

        if (accept)
        begin
            phase_next = cur_phase;
            fc_next    = cur_fc;
            fsz_next   = cur_fsz;
            ci_next    = cur_ci;
            id_next    = cur_id;
            sz_next    = cur_sz;
            rate_next  = cur_rate;
            txt_next   = cur_txt;
            offs_next  = cur_offs;

            if (cur_active)
            begin
                offs_next = cur_offs + 32'd1;
                unique case (cur_phase)
                    PH_FORM:
                    begin
                        fc_next = fc_inc;
                        if ((cur_fc < 32'd4) || (cur_fc >= 32'd8))
                            id_next = id_shifted;
                        else
                            sz_next = sz_shifted;
                        priority if ((cur_fc == 32'd3) && (id_shifted != TAG_FORM))
                        begin
                            phase_next = PH_FAIL;
                            evt_valid  = 1'b1;
                            evt.code   = EV_FORM_BAD;
                        end
                        else if (cur_fc == 32'd7)
                        begin
                            fsz_next = sz_shifted;
                        end
                        else if (cur_fc == 32'd11)
                        begin
                            evt_valid = 1'b1;
                            evt.size  = cur_fsz;
                            if (id_shifted != TAG_8SVX)
                            begin
                                phase_next = PH_FAIL;
                                evt.code   = EV_FORM_BAD;
                            end
                            else
                            begin
                                phase_next = tail_done ? PH_DONE : PH_CHDR;
                                fc_next    = '0;
                                evt.code   = EV_FORM_OK;
                                evt.done   = tail_done;
                            end
                        end
                        else
                        begin
                        end
                    end
                    PH_CHDR:
                    begin
                        if (cur_fc < 32'd4)
                            id_next = id_shifted;
                        else
                            sz_next = sz_shifted;
                        if (cur_fc != 32'd7)
                        begin
                            fc_next = fc_inc;
                        end
                        else
                        begin
                            fc_next   = '0;
                            rate_next = '0;
                            ci_next   = idx_sat;
                            evt.done  = head_done;
                            evt.size  = sz_shifted;
                            priority if (cur_id == TAG_BODY)
                            begin
                                evt_valid  = 1'b1;
                                evt.code   = EV_BODY_START;
                                evt.offset = cur_offs + 32'd1;
                            end
                            else if (is_text_tag(cur_id))
                            begin
                                evt_valid = 1'b1;
                                evt.code  = EV_TEXT;
                                evt.kind  = text_kind_of(cur_id);
                                if ((sz_shifted != 32'd0) && (cur_txt != TEXT_MAX))
                                    txt_next = cur_txt + 16'd1;
                            end
                            else if (cur_id != TAG_VHDR)
                            begin
                                evt_valid = 1'b1;
                                evt.code  = EV_OTHER;
                            end
                            else
                            begin
                            end
                            if (sz_shifted == 32'd0)
                            begin
                                phase_next = head_done ? PH_DONE : PH_CHDR;
                                if (cur_id == TAG_VHDR)
                                begin
                                    evt_valid = 1'b1;
                                    evt.code  = EV_VOICE_HDR;
                                end
                            end
                            else
                            begin
                                phase_next = PH_LOAD;
                            end
                        end
                    end
                    PH_LOAD:
                    begin
                        if (cur_id == TAG_VHDR)
                        begin
                            if (cur_fc == 32'd12)
                                rate_next = {b, 8'h00};
                            else if (cur_fc == 32'd13)
                                rate_next = cur_rate | {8'h00, b};
                        end
                        fc_next = fc_inc;
                        if (fc_inc == cur_sz)
                        begin
                            if (cur_sz[0])
                                phase_next = PH_PAD;
                            else
                                finish = 1'b1;
                        end
                    end
                    PH_PAD:
                    begin
                        finish = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase

                // End of a chunk payload: voice header report or the end of the walk.
                if (finish)
                begin
                    phase_next = tail_done ? PH_DONE : PH_CHDR;
                    fc_next    = '0;
                    if (cur_id == TAG_VHDR)
                    begin
                        evt_valid = 1'b1;
                        evt.code  = EV_VOICE_HDR;
                        evt.done  = tail_done;
                        evt.size  = cur_sz;
                        evt.rate  = rate_next;
                    end
                    else if (tail_done)
                    begin
                        evt_valid = 1'b1;
                        evt.code  = EV_END_ONLY;
                        evt.done  = 1'b1;
                    end
                end
                evt.count = txt_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            fc_reg    <= '0;
            fsz_reg   <= '0;
            ci_reg    <= IDX_START;
            id_reg    <= '0;
            sz_reg    <= '0;
            rate_reg  <= '0;
            txt_reg   <= '0;
            offs_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            fc_reg    <= fc_next;
            fsz_reg   <= fsz_next;
            ci_reg    <= ci_next;
            id_reg    <= id_next;
            sz_reg    <= sz_next;
            rate_reg  <= rate_next;
            txt_reg   <= txt_next;
            offs_reg  <= offs_next;
        end
    end

endmodule

// ===== rtl/core/ifw_queue.sv =====
module ifw_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ifw_pkg::ifw_event_t push_data,
    output logic                space,
    input  logic                pop,
    output logic                head_valid,
    output ifw_pkg::ifw_event_t head_data
);
    import ifw_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

    ifw_event_t       slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_pop;

    assign space      = cnt_reg != DEPTH_CNT;
    assign head_valid = cnt_reg != '0;
    assign head_data  = slot_reg[rd_ptr_reg];
    assign do_pop     = pop & head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !do_pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (!push && do_pop)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== rtl/core/ifw_back.sv =====
module ifw_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  ifw_pkg::ifw_event_t head_data,
    output logic                pop,
    ifw_event_if.source         evt_ch
);
    import ifw_pkg::*;

    logic       valid_reg, valid_next;
    ifw_event_t data_reg;

    // The output register reloads whenever it is empty or being drained.
    assign pop        = head_valid && (!valid_reg || evt_ch.ready);
    assign valid_next = pop ? 1'b1 : (valid_reg && !evt_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            data_reg <= head_data;
    end

    assign evt_ch.valid       = valid_reg;
    assign evt_ch.event_code  = data_reg.code;
    assign evt_ch.parse_done  = data_reg.done;
    assign evt_ch.chunk_size  = data_reg.size;
    assign evt_ch.sample_rate = data_reg.rate;
    assign evt_ch.byte_offset = data_reg.offset;
    assign evt_ch.text_kind   = data_reg.kind;
    assign evt_ch.text_count  = data_reg.count;

endmodule

// ===== rtl/core/iff_8svx_chunk_walker.sv =====
// A result passes through the two-entry result queue and then the output register before it
// is presented. Throughput: one byte per cycle while the queue has space, set by the parser
// front end; the result queue and output register absorb output stalls.
// Reset: rst_n is asynchronous, active low; the parser returns to idle and waits for
// a byte marked start_of_file, and the queue and output register are emptied.
module iff_8svx_chunk_walker (
    input  logic        clk,
    input  logic        rst_n,
    ifw_byte_if.sink    byte_ch,
    ifw_event_if.source evt_ch
);
    import ifw_pkg::*;

    logic       space;
    logic       evt_valid;
    ifw_event_t evt;
    logic       pop;
    logic       head_valid;
    ifw_event_t head_data;

    ifw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_ch   (byte_ch),
        .space     (space),
        .evt_valid (evt_valid),
        .evt       (evt)
    );

    ifw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (evt_valid),
        .push_data  (evt),
        .space      (space),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    ifw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .evt_ch     (evt_ch)
    );

endmodule

// ===== rtl/core/ifw_checker.sv =====
module ifw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  event_code,
    input logic        parse_done,
    input logic [31:0] chunk_size,
    input logic [15:0] sample_rate,
    input logic [31:0] byte_offset
);
    import ifw_pkg::*;

    // A stalled transaction keeps its event code and chunk size.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_code) && $stable(chunk_size))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_code == EV_FORM_BAD) |-> !parse_done)
        else $error("bad form reported as done");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_code != EV_VOICE_HDR) |-> sample_rate == 16'd0)
        else $error("sample rate outside voice header");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_code != EV_BODY_START) |-> byte_offset == 32'd0)
        else $error("byte offset outside body start");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_code == EV_END_ONLY) |-> parse_done && (chunk_size == 32'd0))
        else $error("end event malformed");

endmodule

bind iff_8svx_chunk_walker ifw_checker u_ifw_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (evt_ch.valid),
    .out_ready   (evt_ch.ready),
    .event_code  (evt_ch.event_code),
    .parse_done  (evt_ch.parse_done),
    .chunk_size  (evt_ch.chunk_size),
    .sample_rate (evt_ch.sample_rate),
    .byte_offset (evt_ch.byte_offset)
);

// ===== bench/tb_walk_pkg.sv =====
package tb_walk_pkg;
    import ifw_pkg::*;

    typedef enum logic [2:0] {
        WALK_IDLE,
        WALK_HEAD,
        WALK_CHDR,
        WALK_LOAD,
        WALK_PAD,
        WALK_DONE,
        WALK_FAIL
    } walk_phase_t;

    class walk_scoreboard;
        walk_phase_t phase;
        logic [31:0] field_pos;
        logic [31:0] form_len;
        logic [32:0] walk_index;
        logic [31:0] chunk_id;
        logic [31:0] chunk_len;
        logic [15:0] rate_hold;
        logic [15:0] text_seen;
        logic [31:0] file_pos;
        ifw_event_t  expected_events[$];
        int unsigned error_count;

        function new();
            restart();
            error_count = 0;
        endfunction

        function void restart();
            phase      = WALK_IDLE;
            field_pos  = '0;
            form_len   = '0;
            walk_index = IDX_START;
            chunk_id   = '0;
            chunk_len  = '0;
            rate_hold  = '0;
            text_seen  = '0;
            file_pos   = '0;
        endfunction

        function void expect_event(ifw_code_t code, logic done, logic [31:0] size,
                                   logic [15:0] rate, logic [31:0] offs,
                                   ifw_text_kind_t kind);
            ifw_event_t ev;
            ev.code   = code;
            ev.done   = done;
            ev.size   = size;
            ev.rate   = rate;
            ev.offset = offs;
            ev.kind   = kind;
            ev.count  = text_seen;
            expected_events.push_back(ev);
        endfunction

        // Runs on the last byte of a chunk payload, or on its pad byte.
        function void close_chunk();
            logic done;
            done      = walk_index >= {1'b0, form_len};
            phase     = done ? WALK_DONE : WALK_CHDR;
            field_pos = '0;
            if (chunk_id == TAG_VHDR)
                expect_event(EV_VOICE_HDR, done, chunk_len, rate_hold, '0, TK_NAME);
            else if (done)
                expect_event(EV_END_ONLY, 1'b1, '0, '0, '0, TK_NAME);
        endfunction

        function void take_byte(logic [7:0] b, logic sof);
            logic [31:0]    pos;
            logic [33:0]    nxt;
            logic           done;
            ifw_text_kind_t kind;
            if (sof)
            begin
                restart();
                phase = WALK_HEAD;
            end
            if (!(phase inside {WALK_HEAD, WALK_CHDR, WALK_LOAD, WALK_PAD}))
                return;
            file_pos = file_pos + 1;
            pos = field_pos;
            case (phase)
                WALK_HEAD:
                begin
                    if (pos < 4 || pos >= 8)
                        chunk_id = {chunk_id[23:0], b};
                    else
                        chunk_len = {chunk_len[23:0], b};
                    field_pos = pos + 1;
                    if (pos == 3 && chunk_id != TAG_FORM)
                    begin
                        phase = WALK_FAIL;
                        expect_event(EV_FORM_BAD, 1'b0, '0, '0, '0, TK_NAME);
                    end
                    else if (pos == 7)
                        form_len = chunk_len;
                    else if (pos == 11)
                    begin
                        if (chunk_id != TAG_8SVX)
                        begin
                            phase = WALK_FAIL;
                            expect_event(EV_FORM_BAD, 1'b0, form_len, '0, '0, TK_NAME);
                        end
                        else
                        begin
                            done      = walk_index >= {1'b0, form_len};
                            phase     = done ? WALK_DONE : WALK_CHDR;
                            field_pos = '0;
                            expect_event(EV_FORM_OK, done, form_len, '0, '0, TK_NAME);
                        end
                    end
                end
                WALK_CHDR:
                begin
                    if (pos < 4)
                        chunk_id = {chunk_id[23:0], b};
                    else
                        chunk_len = {chunk_len[23:0], b};
                    if (pos != 7)
                        field_pos = pos + 1;
                    else
                    begin
                        field_pos = '0;
                        rate_hold = '0;
                        // The index moves past the whole chunk, pad included, and
                        // sticks at its top value.
                        nxt = {1'b0, walk_index} + {2'b0, chunk_len} + 34'd8;
                        if (nxt[0])
                            nxt = nxt + 1;
                        if (nxt > {1'b0, IDX_MAX})
                            nxt = {1'b0, IDX_MAX};
                        walk_index = nxt[32:0];
                        done = walk_index >= {1'b0, form_len};
                        case (chunk_id)
                            TAG_BODY:
                                expect_event(EV_BODY_START, done, chunk_len, '0, file_pos,
                                             TK_NAME);
                            TAG_NAME, TAG_AUTH, TAG_COPY, TAG_ANNO:
                            begin
                                case (chunk_id)
                                    TAG_NAME: kind = TK_NAME;
                                    TAG_AUTH: kind = TK_AUTH;
                                    TAG_COPY: kind = TK_COPY;
                                    default:  kind = TK_ANNO;
                                endcase
                                if (chunk_len != 0 && text_seen != TEXT_MAX)
                                    text_seen = text_seen + 1;
                                expect_event(EV_TEXT, done, chunk_len, '0, '0, kind);
                            end
                            TAG_VHDR:
                                ;
                            default:
                                expect_event(EV_OTHER, done, chunk_len, '0, '0, TK_NAME);
                        endcase
                        if (chunk_len == 0)
                        begin
                            phase = done ? WALK_DONE : WALK_CHDR;
                            if (chunk_id == TAG_VHDR)
                                expect_event(EV_VOICE_HDR, done, '0, '0, '0, TK_NAME);
                        end
                        else
                            phase = WALK_LOAD;
                    end
                end
                WALK_LOAD:
                begin
                    if (chunk_id == TAG_VHDR && pos == 12)
                        rate_hold = {b, 8'h00};
                    else if (chunk_id == TAG_VHDR && pos == 13)
                        rate_hold[7:0] = b;
                    field_pos = pos + 1;
                    if (field_pos == chunk_len)
                    begin
                        if (chunk_len[0])
                            phase = WALK_PAD;
                        else
                            close_chunk();
                    end
                end
                default:
                    close_chunk();
            endcase
        endfunction

        function bit field_differs(string name, logic [31:0] want, logic [31:0] got,
                                   time stamp);
            if (want === got)
                return 1'b0;
            $display("%0d ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     stamp, name, want, got);
            return 1'b1;
        endfunction

        function void check_event(ifw_event_t got, time stamp);
            ifw_event_t want;
            bit         bad;
            if (expected_events.size() == 0)
            begin
                error_count++;
                $display("%0d ns: event code %0d with nothing expected, expected none",
                         stamp, got.code);
                return;
            end
            want = expected_events.pop_front();
            bad = 1'b0;
            bad |= field_differs("event_code", want.code, got.code, stamp);
            bad |= field_differs("parse_done", want.done, got.done, stamp);
            bad |= field_differs("chunk_size", want.size, got.size, stamp);
            bad |= field_differs("sample_rate", want.rate, got.rate, stamp);
            bad |= field_differs("byte_offset", want.offset, got.offset, stamp);
            bad |= field_differs("text_kind", want.kind, got.kind, stamp);
            bad |= field_differs("text_count", want.count, got.count, stamp);
            if (bad)
                error_count++;
        endfunction
    endclass

endpackage

// ===== bench/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ifw_pkg::*;
    import tb_walk_pkg::*;

    logic clk = 1'b0;
    logic rst_n;

    ifw_byte_if  byte_ch ();
    ifw_event_if evt_ch ();

    iff_8svx_chunk_walker u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_ch (byte_ch),
        .evt_ch  (evt_ch)
    );

    walk_scoreboard sb = new();

    logic [7:0]  file_bytes[$];
    bit          tx_steady;
    bit          rx_steady;
    bit          hold_req;
    int unsigned random_bytes;
    int unsigned file_no;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        ifw_event_t got;
        if (rst_n === 1'b1)
        begin
            if (byte_ch.valid && byte_ch.ready)
                sb.take_byte(byte_ch.data_byte, byte_ch.start_of_file);
            if (evt_ch.valid && evt_ch.ready)
            begin
                got.code   = ifw_code_t'(evt_ch.event_code);
                got.done   = evt_ch.parse_done;
                got.size   = evt_ch.chunk_size;
                got.rate   = evt_ch.sample_rate;
                got.offset = evt_ch.byte_offset;
                got.kind   = ifw_text_kind_t'(evt_ch.text_kind);
                got.count  = evt_ch.text_count;
                sb.check_event(got, $time);
            end
        end
    end

    // Result side: random stalls, calm runs, and one long hold requested by the sender.
    initial
    begin
        int r;
        evt_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                evt_ch.ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (rx_steady)
                evt_ch.ready <= 1'b1;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                begin
                    evt_ch.ready <= 1'b0;
                    repeat ($urandom_range(15, 50)) @(posedge clk);
                end
                else if (r < 8)
                begin
                    evt_ch.ready <= 1'b1;
                    repeat ($urandom_range(20, 80)) @(posedge clk);
                end
                else
                    evt_ch.ready <= (r >= 30);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic sof);
        int r;
        int gap;
        byte_ch.valid         <= 1'b1;
        byte_ch.data_byte     <= b;
        byte_ch.start_of_file <= sof;
        do
            @(posedge clk);
        while (byte_ch.ready !== 1'b1);
        if (!tx_steady)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                gap = 0;
            else if (r < 88)
                gap = $urandom_range(1, 3);
            else if (r < 97)
                gap = $urandom_range(4, 12);
            else
                gap = $urandom_range(20, 60);
            if (gap > 0)
            begin
                byte_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_file();
        foreach (file_bytes[i])
            send_byte(file_bytes[i], i == 0);
    endtask

    // The first edge lets the monitor take the last accepted byte before the count is read.
    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic void put_be32(logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            file_bytes.push_back(w[8*i +: 8]);
    endfunction

    function automatic void put_random(int n);
        repeat (n) file_bytes.push_back(8'($urandom));
    endfunction

    function automatic void start_form(logic [31:0] len);
        file_bytes.delete();
        put_be32(TAG_FORM);
        put_be32(len);
        put_be32(TAG_8SVX);
    endfunction

    function automatic void add_random_chunk();
        int          r;
        int          len;
        logic [31:0] id;
        r = $urandom_range(0, 99);
        if (r < 20)
        begin
            id = TAG_VHDR;
            case ($urandom_range(0, 6))
                0: len = 0;
                1: len = 1;
                2: len = 12;
                3: len = 13;
                4: len = 14;
                5: len = 16;
                default: len = 20;
            endcase
        end
        else if (r < 40)
        begin
            id  = TAG_BODY;
            len = $urandom_range(0, 24);
        end
        else if (r < 75)
        begin
            case ($urandom_range(0, 3))
                0: id = TAG_NAME;
                1: id = TAG_AUTH;
                2: id = TAG_COPY;
                default: id = TAG_ANNO;
            endcase
            len = $urandom_range(0, 5);
        end
        else
        begin
            id  = $urandom;
            len = $urandom_range(0, 8);
        end
        put_be32(id);
        put_be32(len);
        put_random(len);
        if (len % 2 == 1)
            put_random(1);
    endfunction

    function automatic void build_random_file();
        int          r;
        logic [31:0] total;
        logic [31:0] fs;
        r = $urandom_range(0, 99);
        if (r < 75)
        begin
            start_form('0);
            repeat ($urandom_range(1, 5)) add_random_chunk();
            total = file_bytes.size() - 8;
            r = $urandom_range(0, 99);
            if (r < 70)
                fs = total;
            else if (r < 82)
                fs = $urandom_range(5, total - 1);
            else if (r < 92)
                fs = total + $urandom_range(1, 40);
            else
                fs = $urandom_range(0, 4);
            for (int i = 0; i < 4; i++)
                file_bytes[4 + i] = fs[8*(3 - i) +: 8];
            // Bytes after the end of the walk must be ignored.
            if ($urandom_range(0, 3) == 0)
                put_random($urandom_range(1, 6));
        end
        else if (r < 82)
        begin
            file_bytes.delete();
            if ($urandom_range(0, 1) == 0)
                put_be32(TAG_FORM ^ (32'd1 << $urandom_range(0, 31)));
            else
                put_be32($urandom);
            put_random($urandom_range(0, 8));
        end
        else if (r < 89)
        begin
            file_bytes.delete();
            put_be32(TAG_FORM);
            put_be32($urandom);
            put_be32(TAG_8SVX ^ (32'd1 << $urandom_range(0, 31)));
            put_random($urandom_range(0, 6));
        end
        else if (r < 96)
        begin
            // A huge chunk that the next file cuts short.
            start_form($urandom);
            put_be32(($urandom_range(0, 1) == 0) ? TAG_BODY : 32'($urandom));
            put_be32($urandom);
            put_random($urandom_range(0, 6));
        end
        else
        begin
            file_bytes.delete();
            put_be32(TAG_FORM);
            put_random($urandom_range(0, 6));
        end
    endfunction

    initial
    begin
        rst_n                 = 1'b0;
        byte_ch.valid         = 1'b0;
        byte_ch.data_byte     = '0;
        byte_ch.start_of_file = 1'b0;
        tx_steady             = 1'b0;
        rx_steady             = 1'b0;
        hold_req              = 1'b0;
        random_bytes          = 0;
        file_no               = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Idle bytes with no start mark are dropped.
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h46, 1'b0);

        file_bytes.delete();
        put_be32(TAG_FORM ^ 32'h0000_0001);
        send_file();

        file_bytes.delete();
        put_be32(TAG_FORM);
        put_be32(32'd32);
        put_be32(TAG_8SVX ^ 32'h0100_0000);
        send_file();

        start_form(32'd4);
        put_random(2);
        send_file();

        start_form(32'd0);
        send_file();
        wait_drained();

        // The result side stalls for a long stretch while bytes keep coming.
        hold_req = 1'b1;
        while (random_bytes < 800)
        begin
            build_random_file();
            tx_steady = ($urandom_range(0, 3) == 0);
            send_file();
            random_bytes += file_bytes.size();
            file_no++;
            if (file_no == 10)
                wait_drained();
        end
        tx_steady = 1'b0;
        wait_drained();

        // A new file must restart the text count.
        start_form(32'd14);
        put_be32(TAG_ANNO);
        put_be32(32'd1);
        put_random(2);
        send_file();

        wait_drained();
        repeat (10) @(posedge clk);
        if (sb.error_count == 0)
            $display("[iff_8svx_chunk_walker] OK");
        else
            $display("[iff_8svx_chunk_walker] ERROR");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("%0t ns: timeout with %0d events outstanding", $time,
                 sb.expected_events.size());
        $display("[iff_8svx_chunk_walker] ERROR");
        $finish;
    end

endmodule
